[hw/rtl/rkcc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rkcc_pkg
// Shared widths, codes and transaction types of the keyframe colour cycler.
// ----------------------------------------------------------------------------
package rkcc_pkg;

	localparam int MAX_FRAMES = 16;
	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int FCNT_W     = 5;
	localparam int CYC_W      = 19;
	localparam int DELTA_W    = 16;
	localparam int DUR_W      = 15;
	localparam int FRAC_W     = 16;
	localparam int CHAN_W     = 8;
	localparam int COLOUR_W   = 4 * CHAN_W;
	localparam int CMD_W      = 2;
	localparam int REG_IDX_W  = 2;

	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CYCLE_TIME  = 2'd1;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [DELTA_W-1:0] time_delta;
		logic [FRAME_W-1:0] frame_slot;
		logic [CHAN_W-1:0]  key_red;
		logic [CHAN_W-1:0]  key_green;
		logic [CHAN_W-1:0]  key_blue;
		logic [CHAN_W-1:0]  key_alpha;
		logic [DUR_W-1:0]   key_duration;
	} item_t;

	typedef struct packed {
		logic [CHAN_W-1:0]  out_red;
		logic [CHAN_W-1:0]  out_green;
		logic [CHAN_W-1:0]  out_blue;
		logic [CHAN_W-1:0]  out_alpha;
		logic [FRAME_W-1:0] active_frame;
	} result_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0] reg_index;
		logic [CYC_W-1:0]     wr_data;
	} cfg_wr_t;

endpackage
`default_nettype wire

[hw/rtl/rkcc_item_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rkcc_item_if
// Command channel: valid/ready with one command item as payload.
// ----------------------------------------------------------------------------
interface rkcc_item_if;
	import rkcc_pkg::*;

	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/rkcc_result_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rkcc_result_if
// Result channel: valid/ready with the held colour and active frame.
// ----------------------------------------------------------------------------
interface rkcc_result_if;
	import rkcc_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/rkcc_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rkcc_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface rkcc_cfg_if;
	import rkcc_pkg::*;

	logic    valid;
	logic    ready;
	cfg_wr_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/rgba_keyframe_colour_cycler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_keyframe_colour_cycler
// Looping RGBA keyframe animation. One shared 20-bit subtract/compare unit
// runs the modulo, the frame walk and the fraction divide; one 9x17 multiplier
// blends the four channels one per cycle.
// ----------------------------------------------------------------------------
// Flow: write, unused command or tick with fewer than two frames go straight
// to the result stage; restart first loads the frame 0 colour as held colour;
// tick, when the cycle time is nonzero, runs a 17-step remainder, then a frame
// walk (duration RAM read, then compare, per step), a 16-step divide, the 2
// colour RAM reads and 4 blend steps; zero cycle time skips the remainder.
// One command at a time; a new one is taken while the last result still waits.
// Reset clears position, elapsed time, held colour and frame count and sets the
// cycle time to its least nonzero value; keyframe tables hold no reset value.
// ----------------------------------------------------------------------------
module rgba_keyframe_colour_cycler (
	input  wire logic     clk,
	input  wire logic     arst_n,
	rkcc_item_if.sink     item,
	rkcc_result_if.source result,
	rkcc_cfg_if.sink      cfg
);
	import rkcc_pkg::*;

	localparam int E_W    = DELTA_W + 1;
	localparam int SUB_W  = CYC_W + 1;
	localparam int CNT_W  = 5;
	localparam logic [FCNT_W-1:0] MAX_N = FCNT_W'(MAX_FRAMES);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RST_LD, ST_MOD, ST_WALK_RD, ST_WALK_CMP, ST_DIV,
		ST_RD_C0, ST_RD_C1, ST_LD_C1, ST_BLEND, ST_DONE
	} state_t;

	state_t state_q;

	// keyframe tables
	logic [COLOUR_W-1:0] col_mem [MAX_FRAMES];
	logic [DUR_W-1:0]    dur_mem [MAX_FRAMES];
	logic [COLOUR_W-1:0] col_rd_q;
	logic [DUR_W-1:0]    dur_rd_q;
	logic [FRAME_W-1:0]  col_raddr;

	logic [FCNT_W-1:0]   frame_count_q;
	logic [CYC_W-1:0]    cycle_q;

	logic [FRAME_W-1:0]  pos_q;
	logic [DUR_W-1:0]    elapsed_q;
	logic [COLOUR_W-1:0] held_q;
	logic [FCNT_W-1:0]   n_q;
	logic [E_W-1:0]      e_q;
	logic [CYC_W-1:0]    rem_q;
	logic [DUR_W-1:0]    d_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [1:0]          ch_q;
	logic [COLOUR_W-1:0] c0_q;
	logic [COLOUR_W-1:0] c1_q;

	logic                res_valid_q;
	result_t             res_q;

	logic                in_fire;
	logic [FCNT_W-1:0]   n_now;

	// shared subtract/compare unit
	logic [SUB_W-1:0]    sub_a;
	logic [SUB_W-1:0]    sub_b;
	logic [SUB_W:0]      sub_full;
	logic                borrow;
	logic [SUB_W-1:0]    sub_diff;
	logic [SUB_W-1:0]    rem_next;

	logic [DUR_W-1:0]    dur_eff;
	logic [FCNT_W-1:0]   pos_inc;
	logic [FRAME_W-1:0]  pos_wrap;

	// blend unit
	logic [CHAN_W-1:0]   c0_b;
	logic [CHAN_W-1:0]   c1_b;
	logic signed [CHAN_W:0]       diff_s;
	logic signed [FRAC_W:0]       frac_s;
	logic signed [CHAN_W+FRAC_W+1:0] prod_s;
	logic [CHAN_W-1:0]   blend_b;

	assign item.ready   = (state_q == ST_IDLE);
	assign in_fire      = item.valid && item.ready;
	assign cfg.ready    = 1'b1;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	assign n_now    = (frame_count_q > MAX_N) ? MAX_N : frame_count_q;
	assign dur_eff  = (dur_rd_q == '0) ? DUR_W'(1) : dur_rd_q;
	assign pos_inc  = FCNT_W'(pos_q) + FCNT_W'(1);
	assign pos_wrap = (pos_inc >= n_q) ? '0 : pos_inc[FRAME_W-1:0];

	always_comb begin
		sub_a = '0;
		sub_b = '0;
		case (state_q)
			ST_MOD: begin
				sub_a = {rem_q, e_q[E_W-1]};
				sub_b = SUB_W'(cycle_q);
			end
			ST_WALK_CMP: begin
				sub_a = SUB_W'(e_q);
				sub_b = SUB_W'(dur_eff);
			end
			ST_DIV: begin
				sub_a = {rem_q, 1'b0};
				sub_b = SUB_W'(d_q);
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow   = sub_full[SUB_W];
	assign sub_diff = sub_full[SUB_W-1:0];
	assign rem_next = borrow ? sub_a : sub_diff;

	assign c0_b    = c0_q[{ch_q, 3'b000} +: CHAN_W];
	assign c1_b    = c1_q[{ch_q, 3'b000} +: CHAN_W];
	assign diff_s  = $signed({1'b0, c1_b}) - $signed({1'b0, c0_b});
	assign frac_s  = $signed({1'b0, frac_q});
	assign prod_s  = diff_s * frac_s;
	// low byte of the arithmetic shift plus cur, wrapped to 8 bits
	assign blend_b = prod_s[FRAC_W +: CHAN_W] + c0_b;

	always_comb begin
		case (state_q)
			ST_RD_C0: col_raddr = pos_q;
			ST_RD_C1: col_raddr = pos_wrap;
			default:  col_raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire && (item.data.command == CMD_WRITE)) begin
			col_mem[item.data.frame_slot] <= {item.data.key_alpha, item.data.key_blue,
				item.data.key_green, item.data.key_red};
			dur_mem[item.data.frame_slot] <= item.data.key_duration;
		end
		col_rd_q <= col_mem[col_raddr];
		dur_rd_q <= dur_mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			frame_count_q <= '0;
			cycle_q       <= CYC_W'(1);
			pos_q         <= '0;
			elapsed_q     <= '0;
			held_q        <= '0;
			res_valid_q   <= 1'b0;
			n_q           <= '0;
			cnt_q         <= '0;
			ch_q          <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.reg_index)
					REG_FRAME_COUNT: frame_count_q <= cfg.data.wr_data[FCNT_W-1:0];
					REG_CYCLE_TIME:  cycle_q <= cfg.data.wr_data;
					default: ;
				endcase
			end

			// ST_DONE reloads the result register itself
			if (res_valid_q && result.ready && (state_q != ST_DONE))
				res_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (item.data.command)
							CMD_TICK: begin
								n_q <= n_now;
								if (n_now < FCNT_W'(2)) begin
									state_q <= ST_DONE;
								end else begin
									if (FCNT_W'(pos_q) >= n_now)
										pos_q <= '0;
									e_q   <= E_W'(elapsed_q) + E_W'(item.data.time_delta);
									rem_q <= '0;
									cnt_q <= '0;
									state_q <= (cycle_q != '0) ? ST_MOD : ST_WALK_RD;
								end
							end
							CMD_RESTART: state_q <= ST_RST_LD;
							default:     state_q <= ST_DONE;
						endcase
					end
				end
				ST_RST_LD: begin
					held_q    <= col_rd_q;
					pos_q     <= '0;
					elapsed_q <= '0;
					state_q   <= ST_DONE;
				end
				ST_MOD: begin
					// restoring remainder, one dividend bit per cycle
					rem_q <= rem_next[CYC_W-1:0];
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(E_W - 1)) begin
						e_q     <= rem_next[E_W-1:0];
						state_q <= ST_WALK_RD;
					end else begin
						e_q <= {e_q[E_W-2:0], 1'b0};
					end
				end
				ST_WALK_RD: state_q <= ST_WALK_CMP;
				ST_WALK_CMP: begin
					if (!borrow) begin
						e_q     <= sub_diff[E_W-1:0];
						pos_q   <= pos_wrap;
						state_q <= ST_WALK_RD;
					end else begin
						elapsed_q <= e_q[DUR_W-1:0];
						d_q       <= dur_eff;
						rem_q     <= CYC_W'(e_q[DUR_W-1:0]);
						cnt_q     <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= rem_next[CYC_W-1:0];
					frac_q <= {frac_q[FRAC_W-2:0], ~borrow};
					cnt_q  <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(FRAC_W - 1))
						state_q <= ST_RD_C0;
				end
				ST_RD_C0: state_q <= ST_RD_C1;
				ST_RD_C1: begin
					c0_q    <= col_rd_q;
					state_q <= ST_LD_C1;
				end
				ST_LD_C1: begin
					c1_q    <= col_rd_q;
					ch_q    <= '0;
					state_q <= ST_BLEND;
				end
				ST_BLEND: begin
					held_q[{ch_q, 3'b000} +: CHAN_W] <= blend_b;
					ch_q <= ch_q + 2'd1;
					if (ch_q == 2'd3)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q        <= 1'b1;
						res_q.out_red      <= held_q[0*CHAN_W +: CHAN_W];
						res_q.out_green    <= held_q[1*CHAN_W +: CHAN_W];
						res_q.out_blue     <= held_q[2*CHAN_W +: CHAN_W];
						res_q.out_alpha    <= held_q[3*CHAN_W +: CHAN_W];
						res_q.active_frame <= pos_q;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
